FILE: rtl/psgsrt_pkg.sv
// Package for the sound chip shadow register tracker.
// Holds the command and result types, the address map tables and the lookup
// function. Depends on nothing.
`timescale 1ns / 1ps

package psgsrt_pkg;

    // Physical bytes per chip and chip count default
    localparam int REGS_PER_CHIP     = 25;
    localparam int NUM_CHIPS_DEFAULT = 2;
    localparam int PHYS_W            = 5;

    // Mode/bank/shape register and its fields
    localparam logic [PHYS_W-1:0] MODE_REG        = 5'd13;
    localparam logic [7:0]        UNCHANGED_SHAPE = 8'hFF;
    localparam logic [7:0]        MODE_FIELD      = 8'hE0;
    localparam logic [7:0]        EXP_MODE_CODE   = 8'hA0;
    localparam logic [7:0]        SHAPE_FLAG      = 8'h80;
    localparam logic [7:0]        INDEX_FIELD     = 8'h1F;
    localparam logic [7:0]        NO_REG          = 8'hFF;

    // Command codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_MARK  = 2'd3;

    // Map tables: index byte (shape flag, physical byte) and write mask
    localparam logic [7:0] COM_IDX [32] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h8D, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    localparam logic [7:0] COM_MASK [32] = '{
        8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h1F, 8'h3F,
        8'h1F, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'hEF, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] EXP_IDX [32] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h8D, 8'hFF, 8'hFF,
        8'h0E, 8'h0F, 8'h10, 8'h11, 8'h92, 8'h93, 8'h14, 8'h15,
        8'h16, 8'h17, 8'h18, 8'hFF, 8'hFF, 8'h8D, 8'hFF, 8'hFF};
    localparam logic [7:0] EXP_MASK [32] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'hFF, 8'hFF, 8'hEF, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h0F, 8'h0F, 8'h0F,
        8'h0F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00};

    // Command handed to a chip
    typedef struct packed {
        logic [1:0] func;
        logic [4:0] reg_addr;
        logic [7:0] write_data;
    } cmd_t;

    // Result of one beat
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] diff_byte;
        logic       reg_mapped;
        logic       exp_mode;
        logic       any_change;
    } res_t;

    // Decoded address
    typedef struct packed {
        logic              mapped;
        logic              shape;
        logic [PHYS_W-1:0] phys;
        logic [7:0]        mask;
    } map_t;

    // Look up a logical address in the given mode
    function automatic map_t map_lookup(input logic exp, input logic [4:0] addr);
        map_t       m;
        logic [7:0] code;
        code     = exp ? EXP_IDX[addr] : COM_IDX[addr];
        m.phys   = code[PHYS_W-1:0] & INDEX_FIELD[PHYS_W-1:0];
        m.shape  = (code & SHAPE_FLAG) != 8'h00;
        m.mask   = exp ? EXP_MASK[addr] : COM_MASK[addr];
        m.mapped = (code != NO_REG) && (32'(m.phys) < REGS_PER_CHIP);
        return m;
    endfunction

    // Set of physical bytes reachable in the given mode
    function automatic logic [REGS_PER_CHIP-1:0] used_set(input logic exp);
        logic [REGS_PER_CHIP-1:0] s;
        map_t                     m;
        s = '0;
        for (int a = 0; a < 32; a++)
        begin
            m = map_lookup(exp, a[4:0]);
            if (m.mapped)
            begin
                s[m.phys] = 1'b1;
            end
        end
        return s;
    endfunction

    // True when the mode register selects expanded mode
    function automatic logic is_exp(input logic [7:0] mode_byte);
        return (mode_byte & MODE_FIELD) == EXP_MODE_CODE;
    endfunction

endpackage

FILE: rtl/psgsrt_if.sv
// Valid/ready channel interfaces for the register tracker.
// Request channel carries commands, response channel carries results.
// Depends on nothing.
`timescale 1ns / 1ps

interface psgsrt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       chip;
    logic [4:0] reg_addr;
    logic [7:0] write_data;

    modport source (output valid, func, chip, reg_addr, write_data, input ready);
    modport sink (input valid, func, chip, reg_addr, write_data, output ready);
endinterface

interface psgsrt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] diff_byte;
    logic       reg_mapped;
    logic       exp_mode;
    logic       any_change;

    modport source (output valid, read_data, diff_byte, reg_mapped, exp_mode, any_change,
                    input ready);
    modport sink (input valid, read_data, diff_byte, reg_mapped, exp_mode, any_change,
                  output ready);
endinterface

FILE: rtl/psgsrt_chip.sv
// Shadow registers and change masks of one sound chip.
// Applies one command per enabled cycle and reports the result after it.
// Depends on psgsrt_pkg.
`timescale 1ns / 1ps

module psgsrt_chip
    import psgsrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  cmd_t cmd,
    output res_t res
);

    localparam logic [REGS_PER_CHIP-1:0] USED_COM = used_set(1'b0);
    localparam logic [REGS_PER_CHIP-1:0] USED_EXP = used_set(1'b1);

    logic [7:0] vals_reg   [REGS_PER_CHIP];
    logic [7:0] masks_reg  [REGS_PER_CHIP];
    logic [7:0] vals_next  [REGS_PER_CHIP];
    logic [7:0] masks_next [REGS_PER_CHIP];

    // Apply the command to the current state
    always_comb
    begin
        map_t       pre;
        logic [7:0] data;
        pre  = map_lookup(is_exp(vals_reg[MODE_REG]), cmd.reg_addr);
        data = cmd.write_data & pre.mask;
        for (int p = 0; p < REGS_PER_CHIP; p++)
        begin
            vals_next[p]  = vals_reg[p];
            masks_next[p] = masks_reg[p];
        end
        case (cmd.func)
            FUNC_WRITE:
            begin
                if (pre.mapped)
                begin
                    if (pre.shape)
                    begin
                        if (cmd.write_data != UNCHANGED_SHAPE)
                        begin
                            // Mode change wipes the chip first
                            if (pre.phys == MODE_REG &&
                                ((vals_reg[MODE_REG] ^ data) & MODE_FIELD) != 8'h00)
                            begin
                                for (int p = 0; p < REGS_PER_CHIP; p++)
                                begin
                                    vals_next[p]  = 8'h00;
                                    masks_next[p] = 8'hFF;
                                end
                            end
                            masks_next[pre.phys] = 8'hFF;
                            vals_next[pre.phys]  = data;
                        end
                    end
                    else
                    begin
                        masks_next[pre.phys] = vals_reg[pre.phys] ^ data;
                        vals_next[pre.phys]  = data;
                    end
                end
            end
            FUNC_CLEAR:
            begin
                for (int p = 0; p < REGS_PER_CHIP; p++)
                begin
                    masks_next[p] = 8'h00;
                end
            end
            FUNC_MARK:
            begin
                for (int p = 0; p < REGS_PER_CHIP; p++)
                begin
                    masks_next[p] = 8'hFF;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Report the result from the state after the command
    always_comb
    begin
        map_t                     post;
        logic                     exp_post;
        logic [REGS_PER_CHIP-1:0] used;
        logic [7:0]               diff;
        exp_post = is_exp(vals_next[MODE_REG]);
        post     = map_lookup(exp_post, cmd.reg_addr);
        used     = exp_post ? USED_EXP : USED_COM;
        diff     = post.mapped ? masks_next[post.phys] : 8'h00;
        res.diff_byte  = diff;
        res.reg_mapped = post.mapped;
        res.exp_mode   = exp_post;
        res.read_data  = 8'h00;
        if (post.mapped && cmd.func == FUNC_READ)
        begin
            res.read_data = (post.shape && diff == 8'h00) ? UNCHANGED_SHAPE
                                                           : vals_next[post.phys];
        end
        res.any_change = 1'b0;
        for (int p = 0; p < REGS_PER_CHIP; p++)
        begin
            if (used[p] && masks_next[p] != 8'h00)
            begin
                res.any_change = 1'b1;
            end
        end
    end

    // Commit the new state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < REGS_PER_CHIP; p++)
            begin
                vals_reg[p]  <= 8'h00;
                masks_reg[p] <= 8'h00;
            end
        end
        else if (en)
        begin
            for (int p = 0; p < REGS_PER_CHIP; p++)
            begin
                vals_reg[p]  <= vals_next[p];
                masks_reg[p] <= masks_next[p];
            end
        end
    end

endmodule

FILE: rtl/psg_shadow_register_tracker.sv
// Shadow register tracker for up to two sound chips of the AY-3-8910/AY8930 kind.
//
// Request channel (req): func, chip, reg_addr, write_data. A beat is taken when
// valid and ready are both high. func selects write, read, clear change marks
// or mark all changed; chip picks the register file.
// Response channel (rsp): one beat per request with read_data, diff_byte,
// reg_mapped, exp_mode and any_change, all as seen after the command.
//
// Throughput: one request per cycle while the receiver does not stall; the
// command is held in an input register, applied to the flip-flop register
// file once the output register is free or being taken, and its response is
// captured in the output register at the same edge the file is updated.
// When the receiver stalls, the output register holds its beat and the input
// register stalls behind it, so at most two requests are in flight.
// Reset clears all stored bytes and change masks of every chip (compatibility
// mode) and empties both registers.
// Depends on psgsrt_pkg, psgsrt_if and psgsrt_chip.
`timescale 1ns / 1ps

module psg_shadow_register_tracker
    import psgsrt_pkg::*;
#(
    parameter int NUM_CHIPS = NUM_CHIPS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    psgsrt_req_if.sink   req,
    psgsrt_rsp_if.source rsp
);

    localparam int CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

    logic              in_valid_reg;
    cmd_t              cmd_reg;
    logic [CHIP_W-1:0] chip_reg;
    logic              out_valid_reg;
    res_t              res_reg;
    logic              advance;
    res_t              chip_res [NUM_CHIPS];

    // Move a beat to the output when the output is free or being taken
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // Hold the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            cmd_reg.func       <= req.func;
            cmd_reg.reg_addr   <= req.reg_addr;
            cmd_reg.write_data <= req.write_data;
            // Reduce the chip select to the chips present
            chip_reg <= (NUM_CHIPS > 1) ? CHIP_W'(req.chip) : '0;
        end
    end

    // One register file per chip
    for (genvar i = 0; i < NUM_CHIPS; i++)
    begin : g_chip
        psgsrt_chip u_chip (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (advance && (32'(chip_reg) == i)),
            .cmd   (cmd_reg),
            .res   (chip_res[i])
        );
    end

    // Capture the response of the addressed chip
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= chip_res[chip_reg];
        end
    end

    // Drive the response channel
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = res_reg.read_data;
    assign rsp.diff_byte  = res_reg.diff_byte;
    assign rsp.reg_mapped = res_reg.reg_mapped;
    assign rsp.exp_mode   = res_reg.exp_mode;
    assign rsp.any_change = res_reg.any_change;

endmodule

FILE: sim/testbench.sv
// Testbench for the shadow register tracker: a directed table, then random
// register traffic, each response checked against an in-bench shadow model or a hand-typed response.
// Depends on psgsrt_pkg, psgsrt_if and psg_shadow_register_tracker.
`timescale 1ns / 1ps

module testbench;
    import psgsrt_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_ITEMS  = 2000;
    localparam int CHIPS       = 2;

    // One bus access, with an optional hand-typed response
    typedef struct packed {
        logic [1:0] func;
        logic       chip;
        logic [4:0] addr;
        logic [7:0] data;
        logic       fixed;
        res_t       want;
    } access_t;

    localparam res_t NO_CHECK = '0;

    // Address map per mode: bit 7 shape, bits 4..0 byte, 0xFF unmapped
    localparam logic [7:0] CMP_CODE [32] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h8D, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    localparam logic [7:0] CMP_WMASK [32] = '{
        8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h1F, 8'h3F,
        8'h1F, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'hEF, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] EXT_CODE [32] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h8D, 8'hFF, 8'hFF,
        8'h0E, 8'h0F, 8'h10, 8'h11, 8'h92, 8'h93, 8'h14, 8'h15,
        8'h16, 8'h17, 8'h18, 8'hFF, 8'hFF, 8'h8D, 8'hFF, 8'hFF};
    localparam logic [7:0] EXT_WMASK [32] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'hFF, 8'hFF, 8'hEF, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h0F, 8'h0F, 8'h0F,
        8'h0F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00};

    // Directed table: reset state, field extremes, every command, shape
    // code handling, mode switches, unmapped addresses in both modes
    localparam access_t DIRECTED [25] = '{
        '{FUNC_READ,  1'b0, 5'd0,  8'h00, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b0, 1'b0}},
        '{FUNC_READ,  1'b0, 5'd14, 8'h00, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_READ,  1'b0, 5'd13, 8'h00, 1'b1, '{8'hFF, 8'h00, 1'b1, 1'b0, 1'b0}},
        '{FUNC_WRITE, 1'b0, 5'd0,  8'hFF, 1'b1, '{8'h00, 8'hFF, 1'b1, 1'b0, 1'b1}},
        '{FUNC_WRITE, 1'b0, 5'd1,  8'hFF, 1'b1, '{8'h00, 8'h0F, 1'b1, 1'b0, 1'b1}},
        '{FUNC_WRITE, 1'b0, 5'd13, 8'hFF, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b0, 1'b1}},
        '{FUNC_WRITE, 1'b0, 5'd31, 8'h55, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b1}},
        '{FUNC_CLEAR, 1'b0, 5'd0,  8'h00, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b0, 1'b0}},
        '{FUNC_MARK,  1'b0, 5'd5,  8'h00, 1'b1, '{8'h00, 8'hFF, 1'b1, 1'b0, 1'b1}},
        '{FUNC_WRITE, 1'b0, 5'd13, 8'hA0, 1'b1, '{8'h00, 8'hFF, 1'b1, 1'b1, 1'b1}},
        '{FUNC_READ,  1'b0, 5'd0,  8'h00, 1'b1, '{8'h00, 8'hFF, 1'b1, 1'b1, 1'b1}},
        '{FUNC_WRITE, 1'b0, 5'd29, 8'hB0, 1'b0, NO_CHECK},
        '{FUNC_WRITE, 1'b0, 5'd20, 8'hFF, 1'b0, NO_CHECK},
        '{FUNC_WRITE, 1'b0, 5'd20, 8'h3C, 1'b0, NO_CHECK},
        '{FUNC_READ,  1'b0, 5'd20, 8'h00, 1'b0, NO_CHECK},
        '{FUNC_CLEAR, 1'b0, 5'd0,  8'h00, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1, 1'b0}},
        '{FUNC_READ,  1'b0, 5'd21, 8'h00, 1'b1, '{8'hFF, 8'h00, 1'b1, 1'b1, 1'b0}},
        '{FUNC_READ,  1'b0, 5'd27, 8'h00, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 1'b0}},
        '{FUNC_WRITE, 1'b0, 5'd16, 8'hFF, 1'b0, NO_CHECK},
        '{FUNC_READ,  1'b0, 5'd16, 8'h00, 1'b0, NO_CHECK},
        '{FUNC_WRITE, 1'b1, 5'd7,  8'hFF, 1'b1, '{8'h00, 8'h3F, 1'b1, 1'b0, 1'b1}},
        '{FUNC_WRITE, 1'b1, 5'd13, 8'hE0, 1'b0, NO_CHECK},
        '{FUNC_MARK,  1'b1, 5'd31, 8'h00, 1'b0, NO_CHECK},
        '{FUNC_WRITE, 1'b0, 5'd13, 8'h00, 1'b0, NO_CHECK},
        '{FUNC_READ,  1'b0, 5'd2,  8'h00, 1'b0, NO_CHECK}};

    logic clk = 1'b0;
    logic rst_n;

    psgsrt_req_if req_ch();
    psgsrt_rsp_if rsp_ch();

    psg_shadow_register_tracker dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the register file
    logic [7:0] shadow_val [CHIPS][REGS_PER_CHIP];
    logic [7:0] shadow_chg [CHIPS][REGS_PER_CHIP];

    res_t    pending_results [$];
    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    logic    cur_fixed;
    res_t    cur_want;
    bit      steady         = 1'b0;
    bit      hold_request   = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Decode a logical address in the given mode
    function automatic void decode_addr(input logic ext, input logic [4:0] addr,
                                        output logic hit, output logic is_shape,
                                        output int phys, output logic [7:0] wmask);
        logic [7:0] code;
        code     = ext ? EXT_CODE[addr] : CMP_CODE[addr];
        wmask    = ext ? EXT_WMASK[addr] : CMP_WMASK[addr];
        phys     = int'(code & INDEX_FIELD);
        is_shape = (code & SHAPE_FLAG) != 8'h00;
        hit      = (code != NO_REG) && (phys < REGS_PER_CHIP);
    endfunction

    function automatic logic chip_in_ext(input int c);
        return (shadow_val[c][MODE_REG] & MODE_FIELD) == EXP_MODE_CODE;
    endfunction

    // Apply one access to the shadow file and return the response it gives
    function automatic res_t apply_access(input logic [1:0] func, input logic chip,
                                          input logic [4:0] addr, input logic [7:0] data);
        int         c;
        int         ph;
        int         aph;
        logic       hit;
        logic       shp;
        logic       ahit;
        logic       ashp;
        logic [7:0] m;
        logic [7:0] am;
        logic [7:0] d;
        res_t       r;
        c = int'(chip);
        r = '0;
        case (func)
            FUNC_WRITE:
            begin
                decode_addr(chip_in_ext(c), addr, hit, shp, ph, m);
                d = data & m;
                if (hit && shp && data != UNCHANGED_SHAPE)
                begin
                    // A new mode field wipes the chip and marks everything
                    if (ph == int'(MODE_REG) && ((shadow_val[c][ph] ^ d) & MODE_FIELD) != 0)
                    begin
                        for (int i = 0; i < REGS_PER_CHIP; i++)
                        begin
                            shadow_val[c][i] = 8'h00;
                            shadow_chg[c][i] = 8'hFF;
                        end
                    end
                    shadow_chg[c][ph] = 8'hFF;
                    shadow_val[c][ph] = d;
                end
                else if (hit && !shp)
                begin
                    shadow_chg[c][ph] = shadow_val[c][ph] ^ d;
                    shadow_val[c][ph] = d;
                end
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < REGS_PER_CHIP; i++)
                    shadow_chg[c][i] = 8'h00;
            end
            FUNC_MARK:
            begin
                for (int i = 0; i < REGS_PER_CHIP; i++)
                    shadow_chg[c][i] = 8'hFF;
            end
            default:
            begin
            end
        endcase
        decode_addr(chip_in_ext(c), addr, hit, shp, ph, m);
        if (hit)
        begin
            r.reg_mapped = 1'b1;
            r.diff_byte  = shadow_chg[c][ph];
            if (func == FUNC_READ)
                r.read_data = (shp && shadow_chg[c][ph] == 8'h00) ? UNCHANGED_SHAPE
                                                                  : shadow_val[c][ph];
        end
        for (int a = 0; a < 32; a++)
        begin
            decode_addr(chip_in_ext(c), a[4:0], ahit, ashp, aph, am);
            if (ahit && shadow_chg[c][aph] != 8'h00)
                r.any_change = 1'b1;
        end
        r.exp_mode = chip_in_ext(c);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 19);
        if (k < 12)
            return 0;
        else if (k < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random access, biased toward the mode register so expanded mode is visited
    function automatic access_t rand_access();
        access_t a;
        int      k;
        a       = '0;
        k       = $urandom_range(0, 99);
        a.func  = (k < 45) ? FUNC_WRITE : (k < 80) ? FUNC_READ : (k < 90) ? FUNC_CLEAR
                                                                          : FUNC_MARK;
        a.chip  = 1'($urandom_range(0, 1));
        k       = $urandom_range(0, 99);
        if (k < 10)
        begin
            a.addr = ($urandom_range(0, 1) == 0) ? 5'd13 : 5'd29;
            k      = $urandom_range(0, 9);
            if (k < 5)
                a.data = EXP_MODE_CODE | 8'($urandom_range(0, 31));
            else if (k < 7)
                a.data = UNCHANGED_SHAPE;
            else
                a.data = 8'($urandom_range(0, 255));
        end
        else
        begin
            a.addr = 5'($urandom_range(0, 31));
            k      = $urandom_range(0, 9);
            a.data = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom_range(0, 255));
        end
        return a;
    endfunction

    // Offer one beat on the request channel and hold it until taken
    task automatic offer(input access_t a);
        int g;
        g = steady ? 0 : gap_len();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= a.func;
        req_ch.chip       <= a.chip;
        req_ch.reg_addr   <= a.addr;
        req_ch.write_data <= a.data;
        cur_fixed         <= a.fixed;
        cur_want          <= a.want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding response
    task automatic drain();
        req_ch.valid <= 1'b0;
        // Let the monitor record the last beat before looking at the queue
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                stall_left   = LONG_HOLD - 1;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   = gap_len();
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Predict on each request beat, check each response beat, watch for hangs
    always @(posedge clk)
    begin : monitor
        res_t want;
        bit   moved;
        moved = 1'b0;
        if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        begin
            want = apply_access(req_ch.func, req_ch.chip, req_ch.reg_addr,
                                req_ch.write_data);
            if (cur_fixed)
                want = cur_want;
            pending_results = {pending_results, want};
            moved = 1'b1;
        end
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            moved = 1'b1;
            if (pending_results.size() == 0)
            begin
                $error("response beat with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.read_data !== want.read_data)
                begin
                    $error("read_data: expected %02h, got %02h", want.read_data,
                           rsp_ch.read_data);
                    mismatch_count++;
                end
                if (rsp_ch.diff_byte !== want.diff_byte)
                begin
                    $error("diff_byte: expected %02h, got %02h", want.diff_byte,
                           rsp_ch.diff_byte);
                    mismatch_count++;
                end
                if (rsp_ch.reg_mapped !== want.reg_mapped)
                begin
                    $error("reg_mapped: expected %0b, got %0b", want.reg_mapped,
                           rsp_ch.reg_mapped);
                    mismatch_count++;
                end
                if (rsp_ch.exp_mode !== want.exp_mode)
                begin
                    $error("exp_mode: expected %0b, got %0b", want.exp_mode,
                           rsp_ch.exp_mode);
                    mismatch_count++;
                end
                if (rsp_ch.any_change !== want.any_change)
                begin
                    $error("any_change: expected %0b, got %0b", want.any_change,
                           rsp_ch.any_change);
                    mismatch_count++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Reset, directed table, random traffic, drain and verdict
    initial
    begin : stimulus
        access_t a;
        for (int c = 0; c < CHIPS; c++)
        begin
            for (int i = 0; i < REGS_PER_CHIP; i++)
            begin
                shadow_val[c][i] = 8'h00;
                shadow_chg[c][i] = 8'h00;
            end
        end
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_READ;
        req_ch.chip       <= 1'b0;
        req_ch.reg_addr   <= 5'd0;
        req_ch.write_data <= 8'h00;
        cur_fixed         <= 1'b0;
        cur_want          <= NO_CHECK;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            offer(DIRECTED[i]);

        // Pause until the directed responses are all back
        drain();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            steady = (n >= 300 && n < 500) || (n >= 1300 && n < 1450);
            if (n == 800)
                hold_request = 1'b1;
            if (n == 1000)
                drain();
            a = rand_access();
            offer(a);
        end

        drain();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
